// ----- hw/rtl/md5cx_pkg.sv -----
// Shared types, constants and round tables for the MD5 chained XOR cipher.
package md5cx_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } md5cx_state_t;

    typedef struct packed {
        logic load;
        logic round;
        logic finish;
    } md5cx_cmd_t;

    localparam logic [127:0] FIXED_KEY = 128'h21f3c6d20863aaac38e220620d0d4d52;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [5:0] LAST_ROUND = 6'd63;

    function automatic logic [31:0] sine_const(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/md5cx_ctrl.sv -----
// Sequencer: accepts a word, steps 64 MD5 rounds, presents the result.
module md5cx_ctrl
    import md5cx_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic       out_fire,
    output logic       in_ready,
    output logic       out_valid,
    output logic [5:0] round_idx,
    output md5cx_cmd_t cmd
);

    md5cx_state_t state_reg, state_next;
    logic [5:0]   round_reg, round_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign round_idx = round_reg;

endmodule

// ----- hw/rtl/md5cx_datapath.sv -----
// Datapath: block XOR, one MD5 round per cycle, chain key register.
module md5cx_datapath
    import md5cx_pkg::*;
(
    input  logic         aclk,
    input  md5cx_cmd_t   cmd,
    input  logic [5:0]   round_idx,
    input  logic         encrypt_mode,
    input  logic         start_of_message,
    input  logic [127:0] block_in,
    output logic [127:0] result
);

    logic [127:0] key_reg;
    logic [127:0] result_reg, result_next;
    logic [127:0] msg_reg, msg_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [31:0]  m_word [16];
    logic [31:0]  f, g_word, sum, rot;
    logic [3:0]   g;
    logic [4:0]   s;
    logic [127:0] digest;

    // choose output and hashed message for the incoming word
    always_comb begin
        if (start_of_message) begin
            result_next = block_in;
            msg_next    = block_in ^ FIXED_KEY;
        end else begin
            result_next = block_in ^ key_reg;
            msg_next    = encrypt_mode ? result_next : block_in;
        end
    end

    // message words: byte 0 is the low byte of word 0
    always_comb begin
        for (int w = 0; w < 16; w++) begin
            m_word[w] = 32'h0;
        end
        for (int w = 0; w < 4; w++) begin
            m_word[w] = {msg_reg[127-32*w-24 -: 8], msg_reg[127-32*w-16 -: 8],
                         msg_reg[127-32*w-8 -: 8], msg_reg[127-32*w -: 8]};
        end
        m_word[4]  = 32'h80;
        m_word[14] = 32'd128;
    end

    always_comb begin
        case (round_idx[5:4])
            2'd0: begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = round_idx[3:0];
            end
            2'd1: begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(5 * round_idx[3:0] + 1);
            end
            2'd2: begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(3 * round_idx[3:0] + 5);
            end
            default: begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(7 * round_idx[3:0]);
            end
        endcase
        g_word = m_word[g];
        s      = rot_amount(round_idx);
        sum    = a_reg + f + sine_const(round_idx) + g_word;
        rot    = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    // digest byte 0 is the low byte of the first state word
    always_comb begin
        logic [31:0] st [4];
        st[0] = IV_A + a_reg;
        st[1] = IV_B + b_reg;
        st[2] = IV_C + c_reg;
        st[3] = IV_D + d_reg;
        for (int w = 0; w < 4; w++) begin
            digest[127-32*w -: 32] = {st[w][7:0], st[w][15:8], st[w][23:16], st[w][31:24]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            result_reg <= result_next;
            msg_reg    <= msg_next;
            a_reg      <= IV_A;
            b_reg      <= IV_B;
            c_reg      <= IV_C;
            d_reg      <= IV_D;
        end else if (cmd.round) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
        if (cmd.finish) begin
            key_reg <= digest;
        end
    end

    assign result = result_reg;

endmodule

// ----- hw/rtl/md5_chained_xor_block_cipher.sv -----
// MD5-keyed chained XOR block cipher, top level.
// Each input word passes the round states (64 rounds), the digest add and the output
// state; a new word is taken only after the last result is accepted. The MD5 loop
// runs one round per clock on a single round unit.
// Reset: aresetn synchronous active low clears control and mode; chain key is
// undefined until the digest of the first processed word writes it.
module md5_chained_xor_block_cipher
    import md5cx_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,   // encrypt_mode
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,       // [63:0] block_hi, [127:64] block_lo
    input  logic         s_tuser,       // start_of_message
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata        // [63:0] result_hi, [127:64] result_lo
);

    logic       mode_reg;
    logic [5:0] round_idx;
    md5cx_cmd_t cmd;
    logic [127:0] result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    md5cx_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_tvalid & s_tready),
        .out_fire  (m_tvalid & m_tready),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .round_idx (round_idx),
        .cmd       (cmd)
    );

    md5cx_datapath u_dp (
        .aclk             (aclk),
        .cmd              (cmd),
        .round_idx        (round_idx),
        .encrypt_mode     (mode_reg),
        .start_of_message (s_tuser),
        .block_in         ({s_tdata[63:0], s_tdata[127:64]}),
        .result           (result)
    );

    assign m_tdata = {result[63:0], result[127:64]};

endmodule
